>>> sv/rpbd_pkg.sv
// ----------------------------------------------------------------------------
// rpbd_pkg
// Shared constants for the raster PackBits row decoder: page limits, decode
// phase codes, control byte codes, register indexes and luma weights.
// ----------------------------------------------------------------------------
package rpbd_pkg;

  localparam int unsigned MAX_WIDTH = 4096;

  localparam int unsigned WIDTH_W   = 13;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned ROWS_W    = 17;
  localparam int unsigned REPEAT_W  = 9;
  localparam int unsigned COLUMN_W  = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [1:0] PH_REPEAT  = 2'd0;
  localparam logic [1:0] PH_CONTROL = 2'd1;
  localparam logic [1:0] PH_PIXEL   = 2'd2;

  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  localparam logic [7:0] CTRL_FILL    = 8'd128;
  localparam logic [8:0] LIT_BASE     = 9'd257;
  localparam logic [7:0] FILL_WHITE   = 8'hFF;
  localparam logic [7:0] FILL_BLACK   = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_IS_FF  = 2'd3;

  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

endpackage

>>> sv/raster_packbits_row_decoder.sv
// ----------------------------------------------------------------------------
// raster_packbits_row_decoder
// Decodes the modified PackBits body of a raster page into grey pixel runs.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data_byte) takes one compressed
// byte per transfer. Each row opens with a line-repeat byte, then control
// bytes and pixel bytes until the row is full. A byte that completes a
// pixel or a fill run gives one result on the output channel; other bytes
// give none. A bad page size gives one status result per byte.
// A result is registered and appears on out_valid the cycle after its
// byte's transfer. One byte is taken per cycle while in_stall is low; the
// decode state and the result register are updated in the same cycle.
// When the receiver stalls with a result held, in_stall rises and the
// input waits; the held result does not change until it is taken.
// The cfg_ write port sets image size, color mode and fill value; any
// write restarts the page. Write only while no result is pending.
// Reset (rst_n low, synchronous) clears the decode state, loads register
// defaults (white fill) and empties the result register.
// ----------------------------------------------------------------------------
module raster_packbits_row_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rpbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rpbd_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_pixel_gray,
  output logic [rpbd_pkg::COLUMN_W-1:0]      out_start_column,
  output logic [rpbd_pkg::WIDTH_W-1:0]       out_run_length,
  output logic                               out_row_end,
  output logic [rpbd_pkg::REPEAT_W-1:0]      out_row_repeat,
  output logic                               out_page_end,
  output logic                               out_status
);

  localparam int unsigned WW = rpbd_pkg::WIDTH_W;
  localparam int unsigned HW = rpbd_pkg::HEIGHT_W;
  localparam int unsigned RW = rpbd_pkg::ROWS_W;
  localparam int unsigned PW = rpbd_pkg::REPEAT_W;

  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic          color_r;
  logic          white_r;

  logic [1:0]    phase_r,       phase_nxt;
  logic [WW-1:0] column_r,      column_nxt;
  logic [RW-1:0] rows_r,        rows_nxt;
  logic [PW-1:0] repeat_r,      repeat_nxt;
  logic [WW-1:0] pix_left_r,    pix_left_nxt;
  logic          literal_r,     literal_nxt;
  logic [1:0]    comp_r,        comp_nxt;
  logic [7:0]    red_r,         red_nxt;
  logic [7:0]    green_r,       green_nxt;

  logic                       out_valid_r;
  logic [7:0]                 gray_r,      gray_nxt;
  logic [rpbd_pkg::COLUMN_W-1:0] start_r,  start_nxt;
  logic [WW-1:0]              len_r,       len_nxt;
  logic                       row_end_r,   row_end_nxt;
  logic [PW-1:0]              rep_out_r,   rep_out_nxt;
  logic                       page_end_r,  page_end_nxt;
  logic                       status_r,    status_nxt;
  logic                       res_valid;

  logic          accept;
  logic          bad_size;
  logic [WW-1:0] room;
  logic [7:0]    luma;
  logic          emit;
  logic [7:0]    emit_gray;
  logic [WW-1:0] emit_len;
  logic [WW-1:0] pix_n;
  logic [WW-1:0] pl_dec;
  logic [WW:0]   col_sum;
  logic [RW:0]   rows_sum;
  logic [PW-1:0] rep_n;
  logic [RW-1:0] rows_left;

  function automatic logic [WW-1:0] clamp_room(input logic [WW-1:0] n,
                                               input logic [WW-1:0] lim);
    clamp_room = (n > lim) ? lim : n;
  endfunction

  rpbd_luma u_luma (
    .red   (red_r),
    .green (green_r),
    .blue  (in_data_byte),
    .gray  (luma)
  );

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign bad_size = (width_r == '0) || (width_r > WW'(rpbd_pkg::MAX_WIDTH)) ||
                    (height_r == '0);
  assign room     = (column_r < width_r) ? (width_r - column_r) : '0;
  assign pl_dec   = (pix_left_r != '0) ? (pix_left_r - 1'b1) : '0;
  assign rows_left = (rows_r < RW'(height_r)) ? (RW'(height_r) - rows_r) : RW'(1);

  always_comb begin
    phase_nxt    = phase_r;
    column_nxt   = column_r;
    rows_nxt     = rows_r;
    repeat_nxt   = repeat_r;
    pix_left_nxt = pix_left_r;
    literal_nxt  = literal_r;
    comp_nxt     = comp_r;
    red_nxt      = red_r;
    green_nxt    = green_r;
    res_valid    = 1'b0;
    gray_nxt     = '0;
    start_nxt    = '0;
    len_nxt      = '0;
    row_end_nxt  = 1'b0;
    rep_out_nxt  = '0;
    page_end_nxt = 1'b0;
    status_nxt   = 1'b0;
    emit         = 1'b0;
    emit_gray    = '0;
    emit_len     = '0;
    pix_n        = '0;
    rep_n        = '0;
    col_sum      = '0;
    rows_sum     = '0;

    if (bad_size) begin
      res_valid  = 1'b1;
      status_nxt = 1'b1;
    end else begin
      case (phase_r)
        rpbd_pkg::PH_CONTROL: begin
          if (in_data_byte == rpbd_pkg::CTRL_FILL) begin
            emit      = 1'b1;
            emit_gray = white_r ? rpbd_pkg::FILL_WHITE : rpbd_pkg::FILL_BLACK;
            emit_len  = clamp_room(width_r, room);
          end else begin
            if (in_data_byte > rpbd_pkg::CTRL_FILL) begin
              pix_n       = WW'(rpbd_pkg::LIT_BASE - {1'b0, in_data_byte});
              literal_nxt = 1'b1;
            end else begin
              pix_n       = WW'(in_data_byte) + 1'b1;
              literal_nxt = 1'b0;
            end
            pix_left_nxt = clamp_room(pix_n, room);
            comp_nxt     = rpbd_pkg::COMP_RED;
            phase_nxt    = rpbd_pkg::PH_PIXEL;
          end
        end
        rpbd_pkg::PH_PIXEL: begin
          if (color_r && comp_r == rpbd_pkg::COMP_RED) begin
            red_nxt  = in_data_byte;
            comp_nxt = rpbd_pkg::COMP_GREEN;
          end else if (color_r && comp_r == rpbd_pkg::COMP_GREEN) begin
            green_nxt = in_data_byte;
            comp_nxt  = rpbd_pkg::COMP_BLUE;
          end else begin
            comp_nxt  = color_r ? rpbd_pkg::COMP_RED : comp_r;
            emit_gray = color_r ? luma : in_data_byte;
            if (literal_r) begin
              pix_n        = WW'(1);
              pix_left_nxt = pl_dec;
              if (pl_dec == '0) begin
                phase_nxt = rpbd_pkg::PH_CONTROL;
              end
            end else begin
              pix_n        = pix_left_r;
              pix_left_nxt = '0;
              phase_nxt    = rpbd_pkg::PH_CONTROL;
            end
            emit     = 1'b1;
            emit_len = (pix_n == '0) ? clamp_room(WW'(1), room) : pix_n;
          end
        end
        default: begin
          rep_n      = PW'(in_data_byte) + 1'b1;
          repeat_nxt = (RW'(rep_n) > rows_left) ? PW'(rows_left) : rep_n;
          column_nxt = '0;
          phase_nxt  = rpbd_pkg::PH_CONTROL;
        end
      endcase

      if (emit) begin
        res_valid  = 1'b1;
        gray_nxt   = emit_gray;
        start_nxt  = column_r[rpbd_pkg::COLUMN_W-1:0];
        len_nxt    = emit_len;
        col_sum    = {1'b0, column_r} + {1'b0, emit_len};
        column_nxt = col_sum[WW-1:0];
        if (col_sum >= {1'b0, width_r}) begin
          row_end_nxt  = 1'b1;
          rep_out_nxt  = repeat_r;
          rows_sum     = {1'b0, rows_r} + (RW+1)'(repeat_r);
          rows_nxt     = rows_sum[RW-1:0];
          column_nxt   = '0;
          phase_nxt    = rpbd_pkg::PH_REPEAT;
          pix_left_nxt = '0;
          comp_nxt     = rpbd_pkg::COMP_RED;
          if (rows_sum >= (RW+1)'(height_r)) begin
            page_end_nxt = 1'b1;
            rows_nxt     = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      color_r  <= 1'b0;
      white_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        rpbd_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WW-1:0];
        rpbd_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data[HW-1:0];
        rpbd_pkg::CFG_COLOR_MODE:   color_r  <= cfg_data[0];
        rpbd_pkg::CFG_WHITE_IS_FF:  white_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      phase_r    <= rpbd_pkg::PH_REPEAT;
      column_r   <= '0;
      rows_r     <= '0;
      repeat_r   <= PW'(1);
      pix_left_r <= '0;
      literal_r  <= 1'b0;
      comp_r     <= rpbd_pkg::COMP_RED;
      red_r      <= '0;
      green_r    <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      column_r   <= column_nxt;
      rows_r     <= rows_nxt;
      repeat_r   <= repeat_nxt;
      pix_left_r <= pix_left_nxt;
      literal_r  <= literal_nxt;
      comp_r     <= comp_nxt;
      red_r      <= red_nxt;
      green_r    <= green_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      gray_r     <= gray_nxt;
      start_r    <= start_nxt;
      len_r      <= len_nxt;
      row_end_r  <= row_end_nxt;
      rep_out_r  <= rep_out_nxt;
      page_end_r <= page_end_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_gray   = gray_r;
  assign out_start_column = start_r;
  assign out_run_length   = len_r;
  assign out_row_end      = row_end_r;
  assign out_row_repeat   = rep_out_r;
  assign out_page_end     = page_end_r;
  assign out_status       = status_r;

`ifndef ASSERT_OFF
  a_page_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && page_end_r |-> row_end_r)
    else $error("page end without row end");

  a_pixel_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rpbd_pkg::PH_PIXEL |-> pix_left_r != '0)
    else $error("pixel phase with no pixels left");

  a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != rpbd_pkg::PH_REPEAT |-> column_r < width_r)
    else $error("column beyond row width");

  a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> len_r == '0 && !row_end_r)
    else $error("status result carries a run");
`endif

endmodule

>>> sv/rpbd_luma.sv
// ----------------------------------------------------------------------------
// rpbd_luma
// Integer Rec.601 luma of one RGB pixel: (77 R + 150 G + 29 B) >> 8.
// ----------------------------------------------------------------------------
module rpbd_luma (
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] gray
);

  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [15:0] sum;

  assign prod_r = 16'(red)   * 16'(rpbd_pkg::LUMA_R);
  assign prod_g = 16'(green) * 16'(rpbd_pkg::LUMA_G);
  assign prod_b = 16'(blue)  * 16'(rpbd_pkg::LUMA_B);
  assign sum    = prod_r + prod_g + prod_b;
  assign gray   = sum[15:8];

endmodule
